// File: sv/bracr_pkg.sv
`default_nettype none
// ============================================================================
// bracr_pkg
// Shared types and constants of the banked cartridge RAM and clock block.
// ============================================================================
package bracr_pkg;

    // Default size of the cartridge RAM, in bytes.
    localparam int RAM_BYTES_DEF = 65536;

    // Field and register widths.
    localparam int OP_W      = 3;
    localparam int OFFSET_W  = 13;
    localparam int BYTE_W    = 8;
    localparam int LIMIT_W   = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = LIMIT_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_CLOCK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_RAM = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // Take the input beat and start the RAM read.
        logic commit;   // Apply the captured item and load the result register.
    } t_ctrl_cmd;

endpackage

`default_nettype wire

// File: sv/bracr_ram.sv
`default_nettype none
// ============================================================================
// bracr_ram
// Generic single-port RAM with a registered read.
// ============================================================================
module bracr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic                     i_we,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/bracr_ctrl.sv
`default_nettype none
// ============================================================================
// bracr_ctrl
// Controller: sequences each item through capture and commit and owns the
// valid flag of the result register.
// ============================================================================
module bracr_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output bracr_pkg::t_ctrl_cmd      o_cmd
);
    import bracr_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    // The result register can be loaded when it is empty or drains this cycle.
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: sv/bracr_dp.sv
`default_nettype none
// ============================================================================
// bracr_dp
// Datapath: configuration, bank select, cartridge RAM, real-time clock with
// latch, and the result register.
// ============================================================================
module bracr_dp #(
    parameter int RAM_BYTES = bracr_pkg::RAM_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bracr_pkg::t_ctrl_cmd            i_cmd,
    input  wire logic [bracr_pkg::OP_W-1:0]      i_opcode,
    input  wire logic [bracr_pkg::OFFSET_W-1:0]  i_bus_offset,
    input  wire logic [bracr_pkg::BYTE_W-1:0]    i_data_byte,
    input  wire logic                            i_cfg_we,
    input  wire logic [bracr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bracr_pkg::CFG_W-1:0]     i_cfg_data,
    output logic      [bracr_pkg::BYTE_W-1:0]    o_read_data
);
    import bracr_pkg::*;

    localparam int AW = $clog2(RAM_BYTES);
    localparam logic [LIMIT_W-1:0] RamBytesLim = LIMIT_W'(RAM_BYTES);

    localparam logic [OP_W-1:0] OP_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_BANK  = 3'd2;
    localparam logic [OP_W-1:0] OP_LATCH = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd4;

    localparam logic [3:0] BANK_SEC    = 4'd8;
    localparam logic [3:0] BANK_MIN    = 4'd9;
    localparam logic [3:0] BANK_HOUR   = 4'd10;
    localparam logic [3:0] BANK_DAYLO  = 4'd11;
    localparam logic [3:0] BANK_LAST   = 4'd12;

    function automatic logic [5:0] clamp59(input logic [5:0] v);
        clamp59 = (v > 6'd59) ? 6'd59 : v;
    endfunction

    function automatic logic [4:0] clamp23(input logic [4:0] v);
        clamp23 = (v > 5'd23) ? 5'd23 : v;
    endfunction

    // Configuration registers.
    logic [LIMIT_W-1:0] r_ram_limit;
    logic               r_has_clock;
    logic               r_nibble;

    // Bank and clock state.
    logic [3:0]  r_bank,       n_bank;
    logic [5:0]  r_sec,        n_sec;
    logic [5:0]  r_min,        n_min;
    logic [4:0]  r_hour,       n_hour;
    logic [8:0]  r_days,       n_days;
    logic        r_carry,      n_carry;
    logic        r_halt,       n_halt;
    logic [7:0]  r_last_latch, n_last_latch;
    logic        r_latch_act,  n_latch_act;
    logic [26:0] r_latched,    n_latched;

    // Captured item.
    logic [OP_W-1:0]   r_op;
    logic [BYTE_W-1:0] r_data;
    logic [AW-1:0]     r_ram_idx;
    logic              r_inside;

    logic [BYTE_W-1:0] r_read_data, n_read_data;

    logic [LIMIT_W-1:0] in_addr;
    logic               in_inside;
    logic [AW-1:0]      ram_addr;
    logic               ram_we;
    logic [BYTE_W-1:0]  ram_rdata;
    logic [26:0]        live_time;
    logic [26:0]        view_time;
    logic [BYTE_W-1:0]  clock_value;
    logic [BYTE_W-1:0]  read_value;
    logic               clock_bank;
    logic               latch_fire;

    // Address of the incoming beat in the current bank.
    assign in_addr   = {2'b00, r_bank[2:0], i_bus_offset};
    assign in_inside = (in_addr < r_ram_limit) && (in_addr < RamBytesLim);

    assign clock_bank = (r_bank >= BANK_SEC);
    assign ram_we     = i_cmd.commit && (r_op == OP_WRITE) && !clock_bank && r_inside;
    assign ram_addr   = i_cmd.capture ? in_addr[AW-1:0] : r_ram_idx;

    bracr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_addr  (ram_addr),
        .i_we    (ram_we),
        .i_wdata (r_data),
        .i_re    (i_cmd.capture),
        .o_rdata (ram_rdata)
    );

    // Packed time: seconds, minutes, hours, days, carry from the low end up.
    assign live_time = {r_carry, r_days, r_hour, r_min, r_sec};
    assign view_time = r_latch_act ? r_latched : live_time;

    always_comb begin
        case (r_bank)
            BANK_SEC:   clock_value = {2'b00, view_time[5:0]};
            BANK_MIN:   clock_value = {2'b00, view_time[11:6]};
            BANK_HOUR:  clock_value = {3'b000, view_time[16:12]};
            BANK_DAYLO: clock_value = view_time[24:17];
            default:    clock_value = {view_time[26], r_halt, 5'b00000, view_time[25]};
        endcase
    end

    always_comb begin
        if (clock_bank) begin
            read_value = r_has_clock ? clock_value : 8'hFF;
        end else if (!r_inside) begin
            read_value = 8'hFF;
        end else if (r_nibble) begin
            read_value = {4'h0, ram_rdata[3:0]};
        end else begin
            read_value = ram_rdata;
        end
    end

    assign latch_fire = (r_data == 8'd1) && (r_last_latch == 8'd0);

    always_comb begin
        n_bank       = r_bank;
        n_sec        = r_sec;
        n_min        = r_min;
        n_hour       = r_hour;
        n_days       = r_days;
        n_carry      = r_carry;
        n_halt       = r_halt;
        n_last_latch = r_last_latch;
        n_latch_act  = r_latch_act;
        n_latched    = r_latched;
        n_read_data  = r_read_data;
        if (i_cmd.commit) begin
            n_read_data = 8'h00;
            case (r_op)
                OP_READ: begin
                    n_read_data = read_value;
                end
                OP_WRITE: begin
                    if (clock_bank && r_has_clock) begin
                        case (r_bank)
                            BANK_SEC:   n_sec  = clamp59(r_data[5:0]);
                            BANK_MIN:   n_min  = clamp59(r_data[5:0]);
                            BANK_HOUR:  n_hour = clamp23(r_data[4:0]);
                            BANK_DAYLO: n_days = {r_days[8], r_data};
                            default: begin
                                n_days  = {r_data[0], r_days[7:0]};
                                n_halt  = r_data[6];
                                n_carry = r_data[7];
                            end
                        endcase
                    end
                end
                OP_BANK: begin
                    if (r_data <= {4'h0, BANK_LAST}) begin
                        n_bank = r_data[3:0];
                    end
                end
                OP_LATCH: begin
                    if (r_has_clock) begin
                        if (latch_fire) begin
                            n_latched = live_time;
                        end
                        n_last_latch = r_data;
                        n_latch_act  = latch_fire;
                    end
                end
                OP_TICK: begin
                    // Fields never exceed their maximum, so a match marks the rollover.
                    if (r_has_clock && !r_halt) begin
                        if (r_sec != 6'd59) begin
                            n_sec = r_sec + 6'd1;
                        end else begin
                            n_sec = 6'd0;
                            if (r_min != 6'd59) begin
                                n_min = r_min + 6'd1;
                            end else begin
                                n_min = 6'd0;
                                if (r_hour != 5'd23) begin
                                    n_hour = r_hour + 5'd1;
                                end else begin
                                    n_hour = 5'd0;
                                    if (r_days != 9'd511) begin
                                        n_days = r_days + 9'd1;
                                    end else begin
                                        n_days  = 9'd0;
                                        n_carry = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_read_data = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_limit  <= '0;
            r_has_clock  <= 1'b0;
            r_nibble     <= 1'b0;
            r_bank       <= '0;
            r_sec        <= '0;
            r_min        <= '0;
            r_hour       <= '0;
            r_days       <= '0;
            r_carry      <= 1'b0;
            r_halt       <= 1'b0;
            r_last_latch <= '0;
            r_latch_act  <= 1'b0;
            r_latched    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RAM_LIMIT:  r_ram_limit <= i_cfg_data;
                    CFG_HAS_CLOCK:  r_has_clock <= i_cfg_data[0];
                    CFG_NIBBLE_RAM: r_nibble    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            r_bank       <= n_bank;
            r_sec        <= n_sec;
            r_min        <= n_min;
            r_hour       <= n_hour;
            r_days       <= n_days;
            r_carry      <= n_carry;
            r_halt       <= n_halt;
            r_last_latch <= n_last_latch;
            r_latch_act  <= n_latch_act;
            r_latched    <= n_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_opcode;
            r_data    <= i_data_byte;
            r_ram_idx <= in_addr[AW-1:0];
            r_inside  <= in_inside;
        end
        r_read_data <= n_read_data;
    end

    assign o_read_data = r_read_data;

endmodule

`default_nettype wire

// File: sv/banked_ram_and_clock_registers.sv
`default_nettype none
// ============================================================================
// banked_ram_and_clock_registers
// Cartridge RAM window with bank select and a tick-driven real-time clock.
// ============================================================================
// Each beat passes through capture and commit: at capture the item is captured and the RAM
// read is issued, at commit the registered RAM data is used and the
// state update and result register load happen. Commit waits while an untaken result
// is held, and a new beat is accepted only after the previous one has committed.
// A finished result waits in the output register. RAM contents are undefined
// until written and there is no clearing pass; reads beyond the configured RAM
// limit return 0xFF.
module banked_ram_and_clock_registers #(
    parameter int RAM_BYTES = bracr_pkg::RAM_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [bracr_pkg::OP_W-1:0]      i_opcode,
    input  wire logic [bracr_pkg::OFFSET_W-1:0]  i_bus_offset,
    input  wire logic [bracr_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [bracr_pkg::BYTE_W-1:0]    o_read_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [bracr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bracr_pkg::CFG_W-1:0]     i_cfg_data
);
    import bracr_pkg::*;

    t_ctrl_cmd cmd;

    bracr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    bracr_dp #(
        .RAM_BYTES (RAM_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_opcode),
        .i_bus_offset (i_bus_offset),
        .i_data_byte  (i_data_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_read_data  (o_read_data)
    );

    // A captured beat keeps the input side closed in the following cycle.
    a_busy_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> !o_in_ready)
        else $error("input accepted while an item is still in progress");

    // A commit always presents a result in the next cycle.
    a_result_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out_valid)
        else $error("commit without a result");

    // Capture and commit never fall in the same cycle.
    a_capture_commit_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in one cycle");

    // A commit never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten");

endmodule

`default_nettype wire
